FILE: sv/shtfd_pkg.sv
`default_nettype none
package shtfd_pkg;
  localparam int KEY_W = 64;
  localparam int PORT_W = 16;
  localparam int FD_W = 16;
  localparam int BYTE_IDX_W = 3;
  localparam logic [31:0] HASH_SEED = 32'd5381;

  typedef logic [2:0] cmd_t;
  typedef logic [2:0] status_t;

  localparam cmd_t CMD_LOOKUP = 3'd0;
  localparam cmd_t CMD_INSERT = 3'd1;
  localparam cmd_t CMD_REMOVE = 3'd2;
  localparam cmd_t CMD_FLUSH  = 3'd3;
  localparam cmd_t CMD_PUSH   = 3'd4;
  localparam cmd_t CMD_POP    = 3'd5;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_NOT_FOUND  = 3'd1;
  localparam status_t ST_POOL_FULL  = 3'd2;
  localparam status_t ST_STACK_FULL = 3'd3;
  localparam status_t ST_STACK_EMPTY = 3'd4;
endpackage
`default_nettype wire

FILE: sv/shtfd_if.sv
`default_nettype none
interface shtfd_in_if;
  logic                         valid;
  logic                         ready;
  shtfd_pkg::cmd_t              command;
  logic [shtfd_pkg::KEY_W-1:0]  session_key;
  logic [shtfd_pkg::PORT_W-1:0] port_in;
  logic [shtfd_pkg::FD_W-1:0]   fd_in;
  modport source(output valid, command, session_key, port_in, fd_in, input ready);
  modport sink(input valid, command, session_key, port_in, fd_in, output ready);
endinterface

interface shtfd_out_if;
  logic                         valid;
  logic                         ready;
  shtfd_pkg::status_t           status;
  logic [shtfd_pkg::PORT_W-1:0] port_out;
  logic [shtfd_pkg::FD_W-1:0]   fd_out;
  logic [3:0]                   stack_count;
  logic [3:0]                   bucket;
  modport source(output valid, status, port_out, fd_out, stack_count, bucket, input ready);
  modport sink(input valid, status, port_out, fd_out, stack_count, bucket, output ready);
endinterface
`default_nettype wire

FILE: sv/shtfd_hash.sv
`default_nettype none
module shtfd_hash #(
  parameter int BUCKET_COUNT = 16,
  parameter int KEY_BYTES = 8,
  localparam int BW = $clog2(BUCKET_COUNT)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [shtfd_pkg::KEY_W-1:0] key,
  output logic                             done,
  output logic [BW-1:0]                    bucket
);
  localparam bit IS_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
  localparam logic [1:0] HS_IDLE = 2'd0;
  localparam logic [1:0] HS_MIX  = 2'd1;
  localparam logic [1:0] HS_MOD  = 2'd2;

  logic [1:0]                        state_r, state_nxt;
  logic [31:0]                       h_r, h_nxt;
  logic [shtfd_pkg::KEY_W-1:0]       key_r, key_nxt;
  logic [shtfd_pkg::BYTE_IDX_W-1:0]  idx_r, idx_nxt;
  logic [4:0]                        bit_r, bit_nxt;
  logic [BW-1:0]                     rem_r, rem_nxt;
  logic [BW-1:0]                     bucket_r, bucket_nxt;
  logic                              done_r, done_nxt;
  logic [31:0]                       h_mix;
  logic [BW:0]                       trial;
  logic [BW:0]                       trial_red;

  always_comb begin
    h_mix = (h_r << 5) + h_r + {24'd0, key_r[8*idx_r +: 8]};
    trial = {rem_r, h_r[31]};
    trial_red = (trial >= (BW+1)'(BUCKET_COUNT)) ? trial - (BW+1)'(BUCKET_COUNT) : trial;
    state_nxt = state_r;
    h_nxt = h_r;
    key_nxt = key_r;
    idx_nxt = idx_r;
    bit_nxt = bit_r;
    rem_nxt = rem_r;
    bucket_nxt = bucket_r;
    done_nxt = 1'b0;
    case (state_r)
      HS_IDLE: begin
        if (start) begin
          h_nxt = shtfd_pkg::HASH_SEED;
          key_nxt = key;
          idx_nxt = '0;
          state_nxt = HS_MIX;
        end
      end
      HS_MIX: begin
        h_nxt = h_mix;
        if (idx_r == shtfd_pkg::BYTE_IDX_W'(KEY_BYTES - 1)) begin
          if (IS_POW2) begin
            bucket_nxt = h_mix[BW-1:0];
            done_nxt = 1'b1;
            state_nxt = HS_IDLE;
          end else begin
            rem_nxt = '0;
            bit_nxt = '0;
            state_nxt = HS_MOD;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      HS_MOD: begin
        rem_nxt = trial_red[BW-1:0];
        h_nxt = h_r << 1;
        if (bit_r == 5'd31) begin
          bucket_nxt = trial_red[BW-1:0];
          done_nxt = 1'b1;
          state_nxt = HS_IDLE;
        end else begin
          bit_nxt = bit_r + 1'b1;
        end
      end
      default: state_nxt = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= HS_IDLE;
      done_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r <= done_nxt;
    end
    h_r <= h_nxt;
    key_r <= key_nxt;
    idx_r <= idx_nxt;
    bit_r <= bit_nxt;
    rem_r <= rem_nxt;
    bucket_r <= bucket_nxt;
  end

  assign done = done_r;
  assign bucket = bucket_r;

  a_mod_only_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == HS_MOD) |-> !IS_POW2) else $error("remainder phase on power-of-two table");
  a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(state_r) != HS_IDLE) else $error("done without hashing");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> bucket_r < BW'(BUCKET_COUNT - 1) || bucket_r == BW'(BUCKET_COUNT - 1))
    else $error("bucket out of range");
endmodule
`default_nettype wire

FILE: sv/session_hash_table_fd_stack.sv
// Operation: the key is hashed byte by byte (with a bit-serial remainder phase when
//   BUCKET_COUNT is not a power of two), then the bucket head is read and the chain is
//   walked entry by entry to the match or the chain end; an insert instead tests pool
//   entries for a free one, a pop reads the stack slot, and the result is registered.
// Throughput: one item at a time; in_chan.ready is high only in the idle state.
// Reset: synchronous, active low; clears control and bucket head valid bits; sets the free map to all free.
`default_nettype none
module session_hash_table_fd_stack #(
  parameter int BUCKET_COUNT = 16,
  parameter int KEY_BYTES = 8,
  parameter int STACK_DEPTH = 8,
  parameter int POOL_ENTRIES = 64
) (
  input wire logic   clk,
  input wire logic   rst_n,
  shtfd_in_if.sink   in_chan,
  shtfd_out_if.source out_chan
);
  localparam int BW = $clog2(BUCKET_COUNT);
  localparam int PW = $clog2(POOL_ENTRIES + 1);
  localparam int IW = $clog2(POOL_ENTRIES);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = $clog2(POOL_ENTRIES * STACK_DEPTH);
  localparam logic [PW-1:0] NULL_LINK = PW'(POOL_ENTRIES);
  localparam logic [63:0] KEY_MASK =
    (KEY_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HASH = 4'd1;
  localparam logic [3:0] S_HEAD = 4'd2;
  localparam logic [3:0] S_SEL  = 4'd3;
  localparam logic [3:0] S_FREE = 4'd4;
  localparam logic [3:0] S_WRD  = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_POP  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]                   state_r, state_nxt;
  shtfd_pkg::cmd_t              cmd_r, cmd_nxt;
  logic [63:0]                  key_r, key_nxt;
  logic [15:0]                  port_r, port_nxt;
  logic [15:0]                  fd_r, fd_nxt;
  logic [BW-1:0]                bkt_r, bkt_nxt;
  logic [PW-1:0]                cur_r, cur_nxt;
  logic [PW-1:0]                prev_r, prev_nxt;
  logic [PW-1:0]                steps_r, steps_nxt;
  logic [PW-1:0]                scan_r, scan_nxt;
  shtfd_pkg::status_t           res_status_r, res_status_nxt;
  logic [15:0]                  res_port_r, res_port_nxt;
  logic [15:0]                  res_fd_r, res_fd_nxt;
  logic [3:0]                   res_cnt_r, res_cnt_nxt;
  logic [BUCKET_COUNT-1:0]      head_vld_r, head_vld_nxt;
  logic [POOL_ENTRIES-1:0]      free_r, free_nxt;
  logic                         out_vld_r;
  shtfd_pkg::status_t           out_status_r;
  logic [15:0]                  out_port_r, out_fd_r;
  logic [3:0]                   out_cnt_r, out_bkt_r;

  logic [63:0]     key_mem [POOL_ENTRIES];
  logic [15:0]     port_mem [POOL_ENTRIES];
  logic [PW-1:0]   link_mem [POOL_ENTRIES];
  logic [CW-1:0]   cnt_mem [POOL_ENTRIES];
  logic [15:0]     stk_mem [POOL_ENTRIES * STACK_DEPTH];
  logic [PW-1:0]   head_mem [BUCKET_COUNT];
  logic [63:0]     key_q;
  logic [15:0]     port_q, stk_q;
  logic [PW-1:0]   link_q, head_q;
  logic [CW-1:0]   cnt_q;

  logic            ent_we, link_we, cnt_we, stk_we, head_we;
  logic [IW-1:0]   ent_wa, link_wa, cnt_wa, cur_idx;
  logic [PW-1:0]   link_wd, head_wd;
  logic [CW-1:0]   cnt_wd, cnt_sel;
  logic [SAW-1:0]  stk_addr;
  logic            in_acc, hash_done, out_load;
  logic [BW-1:0]   hash_bkt;

  assign in_acc = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign cur_idx = cur_r[IW-1:0];
  assign cnt_sel = (cmd_r == shtfd_pkg::CMD_POP) ? cnt_q - 1'b1 : cnt_q;
  assign stk_addr = SAW'(cur_idx) * SAW'(STACK_DEPTH) + SAW'(cnt_sel);
  assign out_load = (state_r == S_DONE) && (!out_vld_r || out_chan.ready);

  shtfd_hash #(.BUCKET_COUNT(BUCKET_COUNT), .KEY_BYTES(KEY_BYTES)) u_hash (
    .clk(clk), .rst_n(rst_n), .start(in_acc),
    .key(in_chan.session_key & KEY_MASK), .done(hash_done), .bucket(hash_bkt)
  );

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    key_nxt = key_r;
    port_nxt = port_r;
    fd_nxt = fd_r;
    bkt_nxt = bkt_r;
    cur_nxt = cur_r;
    prev_nxt = prev_r;
    steps_nxt = steps_r;
    scan_nxt = scan_r;
    res_status_nxt = res_status_r;
    res_port_nxt = res_port_r;
    res_fd_nxt = res_fd_r;
    res_cnt_nxt = res_cnt_r;
    head_vld_nxt = head_vld_r;
    free_nxt = free_r;
    ent_we = 1'b0;
    ent_wa = scan_r[IW-1:0];
    link_we = 1'b0;
    link_wa = prev_r[IW-1:0];
    link_wd = link_q;
    cnt_we = 1'b0;
    cnt_wa = scan_r[IW-1:0];
    cnt_wd = '0;
    stk_we = 1'b0;
    head_we = 1'b0;
    head_wd = link_q;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt = in_chan.command;
          key_nxt = in_chan.session_key & KEY_MASK;
          port_nxt = in_chan.port_in;
          fd_nxt = in_chan.fd_in;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          bkt_nxt = hash_bkt;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: state_nxt = S_SEL;
      S_SEL: begin
        cur_nxt = head_vld_r[bkt_r] ? head_q : NULL_LINK;
        prev_nxt = NULL_LINK;
        steps_nxt = '0;
        scan_nxt = '0;
        res_status_nxt = shtfd_pkg::ST_OK;
        res_port_nxt = '0;
        res_fd_nxt = '0;
        res_cnt_nxt = '0;
        case (cmd_r)
          shtfd_pkg::CMD_FLUSH: begin
            head_vld_nxt = '0;
            free_nxt = '1;
            state_nxt = S_DONE;
          end
          shtfd_pkg::CMD_INSERT: state_nxt = S_FREE;
          shtfd_pkg::CMD_LOOKUP, shtfd_pkg::CMD_REMOVE,
          shtfd_pkg::CMD_PUSH, shtfd_pkg::CMD_POP: state_nxt = S_WRD;
          default: state_nxt = S_DONE;
        endcase
      end
      S_FREE: begin
        if (free_r[scan_r[IW-1:0]]) begin
          ent_we = 1'b1;
          cnt_we = 1'b1;
          cnt_wd = '0;
          head_we = 1'b1;
          head_wd = scan_r;
          head_vld_nxt[bkt_r] = 1'b1;
          free_nxt[scan_r[IW-1:0]] = 1'b0;
          state_nxt = S_DONE;
        end else if (scan_r == PW'(POOL_ENTRIES - 1)) begin
          res_status_nxt = shtfd_pkg::ST_POOL_FULL;
          state_nxt = S_DONE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_WRD: begin
        if (cur_r >= NULL_LINK || steps_r == PW'(POOL_ENTRIES)) begin
          res_status_nxt = shtfd_pkg::ST_NOT_FOUND;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (key_q == key_r) begin
          state_nxt = S_DONE;
          case (cmd_r)
            shtfd_pkg::CMD_LOOKUP: begin
              res_port_nxt = port_q;
              res_cnt_nxt = 4'(cnt_q);
            end
            shtfd_pkg::CMD_REMOVE: begin
              if (prev_r == NULL_LINK) begin
                head_we = 1'b1;
                head_wd = link_q;
              end else begin
                link_we = 1'b1;
              end
              free_nxt[cur_idx] = 1'b1;
            end
            shtfd_pkg::CMD_PUSH: begin
              if (cnt_q >= CW'(STACK_DEPTH)) begin
                res_status_nxt = shtfd_pkg::ST_STACK_FULL;
                res_cnt_nxt = 4'(cnt_q);
              end else begin
                stk_we = 1'b1;
                cnt_we = 1'b1;
                cnt_wa = cur_idx;
                cnt_wd = cnt_q + 1'b1;
                res_cnt_nxt = 4'(cnt_q + 1'b1);
              end
            end
            shtfd_pkg::CMD_POP: begin
              if (cnt_q == '0) begin
                res_status_nxt = shtfd_pkg::ST_STACK_EMPTY;
              end else begin
                cnt_we = 1'b1;
                cnt_wa = cur_idx;
                cnt_wd = cnt_sel;
                res_cnt_nxt = 4'(cnt_sel);
                state_nxt = S_POP;
              end
            end
            default: ;
          endcase
        end else begin
          prev_nxt = cur_r;
          cur_nxt = link_q;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_WRD;
        end
      end
      S_POP: begin
        res_fd_nxt = stk_q;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      key_mem[ent_wa] <= key_r;
      port_mem[ent_wa] <= port_r;
    end
    key_q <= key_mem[cur_idx];
    port_q <= port_mem[cur_idx];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      link_mem[ent_wa] <= cur_r;
    end else if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_q <= link_mem[cur_idx];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q <= cnt_mem[cur_idx];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_addr] <= fd_r;
    stk_q <= stk_mem[stk_addr];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[bkt_r] <= head_wd;
    head_q <= head_mem[bkt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_vld_r <= '0;
      free_r <= '1;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_vld_r <= head_vld_nxt;
      free_r <= free_nxt;
      if (out_load) out_vld_r <= 1'b1;
      else if (out_chan.ready) out_vld_r <= 1'b0;
    end
    cmd_r <= cmd_nxt;
    key_r <= key_nxt;
    port_r <= port_nxt;
    fd_r <= fd_nxt;
    bkt_r <= bkt_nxt;
    cur_r <= cur_nxt;
    prev_r <= prev_nxt;
    steps_r <= steps_nxt;
    scan_r <= scan_nxt;
    res_status_r <= res_status_nxt;
    res_port_r <= res_port_nxt;
    res_fd_r <= res_fd_nxt;
    res_cnt_r <= res_cnt_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_port_r <= res_port_r;
      out_fd_r <= res_fd_r;
      out_cnt_r <= res_cnt_r;
      out_bkt_r <= 4'(bkt_r);
    end
  end

  assign out_chan.valid = out_vld_r;
  assign out_chan.status = out_status_r;
  assign out_chan.port_out = out_port_r;
  assign out_chan.fd_out = out_fd_r;
  assign out_chan.stack_count = out_cnt_r;
  assign out_chan.bucket = out_bkt_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_HASH) else $error("item accepted but not started");
  a_cmp_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> cur_r < NULL_LINK) else $error("chain walk off the pool");
  a_not_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_status_r == shtfd_pkg::ST_NOT_FOUND) |->
      (out_port_r == '0 && out_cnt_r == '0 && out_fd_r == '0))
    else $error("not-found result carries data");
  a_hash_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> state_r == S_HASH) else $error("hash result with no item waiting");
endmodule
`default_nettype wire
